// ===== hw/rtl/clws_pkg.sv =====
// package for the character lcd write sequencer
// holds payload structs, op codes, phase and sequence encodings and the sequence tables
// no dependencies
package clws_pkg;

    localparam int CFG_WIDTH     = 20;
    localparam int NUM_REGS      = 7;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int STEP_WIDTH    = 4;
    localparam int QUEUE_DEPTH   = 2;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SETUP      = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PULSE      = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_HOLD       = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CLEAR_WAIT = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_POWERUP    = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WAKE_FIRST = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WAKE_LATER = 3'd6;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] RST_SETUP      = 20'd240;
    localparam logic [CFG_WIDTH-1:0] RST_PULSE      = 20'd240;
    localparam logic [CFG_WIDTH-1:0] RST_HOLD       = 20'd1600;
    localparam logic [CFG_WIDTH-1:0] RST_CLEAR_WAIT = 20'd64000;
    localparam logic [CFG_WIDTH-1:0] RST_POWERUP    = 20'd600000;
    localparam logic [CFG_WIDTH-1:0] RST_WAKE_FIRST = 20'd200000;
    localparam logic [CFG_WIDTH-1:0] RST_WAKE_LATER = 20'd6400;

    // request function codes
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_CMD   = 3'd1;
    localparam logic [2:0] FUNC_CHAR  = 3'd2;
    localparam logic [2:0] FUNC_CLEAR = 3'd3;
    localparam logic [2:0] FUNC_INIT  = 3'd4;

    // lcd command bytes
    localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
    localparam logic [7:0] LCD_HOME      = 8'h02;
    localparam logic [7:0] LCD_WAKE      = 8'h30;
    localparam logic [7:0] LCD_FUNC_SET  = 8'h38;
    localparam logic [7:0] LCD_SHIFT     = 8'h10;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] byte_value;
    } clws_in_t;

    typedef struct packed {
        logic [7:0] data_pins;
        logic       rs_pin;
        logic       e_pin;
        logic       busy_res;
        logic       rejected;
    } clws_out_t;

    // classified operation carried from front to back
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_CMD   = 3'd1,
        OP_CHAR  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_INIT  = 3'd4,
        OP_NOP   = 3'd5
    } clws_op_kind_t;

    typedef struct packed {
        clws_op_kind_t kind;
        logic [7:0]    byte_value;
    } clws_op_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_SETUP = 5'b00010,
        PH_PULSE = 5'b00100,
        PH_HOLD  = 5'b01000,
        PH_WAIT  = 5'b10000
    } clws_phase_t;

    typedef enum logic [2:0] {
        SEQ_NONE  = 3'b001,
        SEQ_CLEAR = 3'b010,
        SEQ_INIT  = 3'b100
    } clws_seq_t;

    typedef struct packed {
        logic                     present;
        logic                     is_wait;
        logic [CFG_IDX_WIDTH-1:0] reg_idx;
        logic [7:0]               byte_value;
    } clws_seq_item_t;

    function automatic clws_seq_item_t seq_write(input logic [7:0] b);
        clws_seq_item_t it;
        it.present    = 1'b1;
        it.is_wait    = 1'b0;
        it.reg_idx    = REG_SETUP;
        it.byte_value = b;
        return it;
    endfunction

    function automatic clws_seq_item_t seq_wait(input logic [CFG_IDX_WIDTH-1:0] idx);
        clws_seq_item_t it;
        it.present    = 1'b1;
        it.is_wait    = 1'b1;
        it.reg_idx    = idx;
        it.byte_value = 8'h00;
        return it;
    endfunction

    // entry of the clear or init sequence; not present past the end
    function automatic clws_seq_item_t seq_lookup(input clws_seq_t kind,
                                                  input logic [STEP_WIDTH-1:0] step);
        clws_seq_item_t it;
        it = '0;
        case (kind)
            SEQ_CLEAR:
            begin
                case (step)
                    4'd0:    it = seq_write(LCD_CLR_DISP);
                    4'd1:    it = seq_wait(REG_CLEAR_WAIT);
                    4'd2:    it = seq_write(LCD_HOME);
                    4'd3:    it = seq_wait(REG_CLEAR_WAIT);
                    default: it = '0;
                endcase
            end
            SEQ_INIT:
            begin
                case (step)
                    4'd0:    it = seq_wait(REG_POWERUP);
                    4'd1:    it = seq_write(LCD_WAKE);
                    4'd2:    it = seq_wait(REG_WAKE_FIRST);
                    4'd3:    it = seq_write(LCD_WAKE);
                    4'd4:    it = seq_wait(REG_WAKE_LATER);
                    4'd5:    it = seq_write(LCD_WAKE);
                    4'd6:    it = seq_wait(REG_WAKE_LATER);
                    4'd7:    it = seq_write(LCD_FUNC_SET);
                    4'd8:    it = seq_write(LCD_SHIFT);
                    4'd9:    it = seq_write(LCD_DISP_ON);
                    4'd10:   it = seq_write(LCD_ENTRY);
                    default: it = '0;
                endcase
            end
            default: it = '0;
        endcase
        return it;
    endfunction

endpackage

// ===== hw/rtl/clws_front.sv =====
// front end of the lcd write sequencer: takes request transactions and classifies them
// depends on clws_pkg
module clws_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  clws_pkg::clws_in_t in_data,
    input  logic              q_full,
    output logic              q_push,
    output clws_pkg::clws_op_t q_wdata
);
    import clws_pkg::*;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_wdata.byte_value = in_data.byte_value;
        case (in_data.func)
            FUNC_TICK:  q_wdata.kind = OP_TICK;
            FUNC_CMD:   q_wdata.kind = OP_CMD;
            FUNC_CHAR:  q_wdata.kind = OP_CHAR;
            FUNC_CLEAR: q_wdata.kind = OP_CLEAR;
            FUNC_INIT:  q_wdata.kind = OP_INIT;
            default:    q_wdata.kind = OP_NOP;
        endcase
    end

endmodule

// ===== hw/rtl/clws_queue.sv =====
// two-entry queue of classified operations between front and back
// depends on clws_pkg
module clws_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  clws_pkg::clws_op_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output clws_pkg::clws_op_t rdata
);
    import clws_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    clws_op_t               mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/clws_back.sv =====
// back end of the lcd write sequencer: strobe timing, sequences, config registers, result register
// depends on clws_pkg
module clws_back #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [clws_pkg::CFG_IDX_WIDTH-1:0]    cfg_addr,
    input  logic [clws_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    input  logic                                  q_not_empty,
    input  clws_pkg::clws_op_t                    q_rdata,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output clws_pkg::clws_out_t                   out_data
);
    import clws_pkg::*;

    logic [CFG_WIDTH-1:0]   cfg_reg [NUM_REGS];

    clws_phase_t            phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   rs_reg, rs_next;
    clws_seq_t              kind_reg, kind_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic                   rej;

    logic                   out_valid_reg;
    clws_out_t              out_data_reg;

    logic                   run;
    clws_seq_t              run_kind;
    logic [STEP_WIDTH-1:0]  run_step;
    clws_seq_item_t         run_item;
    logic [CFG_WIDTH-1:0]   wait_cfg;
    logic                   busy;

    assign q_pop     = q_not_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign busy      = (phase_reg != PH_IDLE);

    // entry to start: first one of a new sequence, else the one after the current
    always_comb
    begin
        case (q_rdata.kind)
            OP_CLEAR:
            begin
                run_kind = SEQ_CLEAR;
                run_step = '0;
            end
            OP_INIT:
            begin
                run_kind = SEQ_INIT;
                run_step = '0;
            end
            default:
            begin
                run_kind = kind_reg;
                run_step = step_reg + STEP_WIDTH'(1);
            end
        endcase
    end

    assign run_item = seq_lookup(run_kind, run_step);

    always_comb
    begin
        case (run_item.reg_idx)
            REG_SETUP:      wait_cfg = cfg_reg[0];
            REG_PULSE:      wait_cfg = cfg_reg[1];
            REG_HOLD:       wait_cfg = cfg_reg[2];
            REG_CLEAR_WAIT: wait_cfg = cfg_reg[3];
            REG_POWERUP:    wait_cfg = cfg_reg[4];
            REG_WAKE_FIRST: wait_cfg = cfg_reg[5];
            REG_WAKE_LATER: wait_cfg = cfg_reg[6];
            default:        wait_cfg = cfg_reg[0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        byte_next  = byte_reg;
        rs_next    = rs_reg;
        kind_next  = kind_reg;
        step_next  = step_reg;
        rej        = 1'b0;
        run        = 1'b0;

        case (q_rdata.kind)
            OP_TICK:
            begin
                if (busy)
                begin
                    if (count_reg > COUNT_WIDTH'(1))
                    begin
                        count_next = count_reg - COUNT_WIDTH'(1);
                    end
                    else if (phase_reg == PH_SETUP)
                    begin
                        phase_next = PH_PULSE;
                        count_next = COUNT_WIDTH'(cfg_reg[1]);
                    end
                    else if (phase_reg == PH_PULSE)
                    begin
                        phase_next = PH_HOLD;
                        count_next = COUNT_WIDTH'(cfg_reg[2]);
                    end
                    else
                    begin
                        // end of hold or wait: next sequence entry
                        run = 1'b1;
                    end
                end
            end
            OP_CMD, OP_CHAR:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    kind_next  = SEQ_NONE;
                    step_next  = '0;
                    byte_next  = q_rdata.byte_value;
                    rs_next    = (q_rdata.kind == OP_CHAR);
                    phase_next = PH_SETUP;
                    count_next = COUNT_WIDTH'(cfg_reg[0]);
                end
            end
            OP_CLEAR, OP_INIT:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    run = 1'b1;
                    if (q_rdata.kind == OP_INIT)
                    begin
                        rs_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (run)
        begin
            kind_next = run_kind;
            step_next = run_step;
            if (!run_item.present)
            begin
                phase_next = PH_IDLE;
                count_next = '0;
                kind_next  = SEQ_NONE;
                step_next  = '0;
            end
            else if (run_item.is_wait)
            begin
                phase_next = PH_WAIT;
                count_next = COUNT_WIDTH'(wait_cfg);
            end
            else
            begin
                byte_next  = run_item.byte_value;
                rs_next    = 1'b0;
                phase_next = PH_SETUP;
                count_next = COUNT_WIDTH'(cfg_reg[0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= RST_SETUP;
            cfg_reg[1] <= RST_PULSE;
            cfg_reg[2] <= RST_HOLD;
            cfg_reg[3] <= RST_CLEAR_WAIT;
            cfg_reg[4] <= RST_POWERUP;
            cfg_reg[5] <= RST_WAKE_FIRST;
            cfg_reg[6] <= RST_WAKE_LATER;
        end
        else if (cfg_we && (cfg_addr < CFG_IDX_WIDTH'(NUM_REGS)))
        begin
            // a written zero is stored as one
            cfg_reg[cfg_addr] <= (cfg_wdata == '0) ? CFG_WIDTH'(1) : cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            byte_reg      <= '0;
            rs_reg        <= 1'b0;
            kind_reg      <= SEQ_NONE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                byte_reg      <= byte_next;
                rs_reg        <= rs_next;
                kind_reg      <= kind_next;
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg.data_pins <= byte_next;
            out_data_reg.rs_pin    <= rs_next;
            out_data_reg.e_pin     <= (phase_next == PH_PULSE);
            out_data_reg.busy_res  <= (phase_next != PH_IDLE);
            out_data_reg.rejected  <= rej;
        end
    end

endmodule

// ===== hw/rtl/char_lcd_write_sequencer_unit.sv =====
// top level of the character lcd write sequencer
// depends on clws_pkg, clws_front, clws_queue, clws_back
//
// Drives the 8-bit write bus of a character LCD (data lines, RS, E). Each input
// transaction is a tick, a command byte, a character byte, a clear sequence or the
// power-up init sequence; each one yields exactly one result transaction showing the
// bus levels, busy and whether the request was dropped because a write was still in
// progress. One transaction is taken every clock cycle as long as results are taken:
// the front decodes the request into a two-entry queue, and the back applies one
// queued operation per cycle (one countdown decrement or phase load) into a result
// register. A request passes a queue entry, then the result register; the throughput of
// one per cycle is set by the back's state update, which holds while a result is not
// taken. Timing is in ticks, so real delays scale with how often ticks are sent.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata, take effect
// at the next phase load, a written zero acts as one. There is no clearing pass after reset.
module char_lcd_write_sequencer_unit #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [clws_pkg::CFG_IDX_WIDTH-1:0]  cfg_addr,
    input  logic [clws_pkg::CFG_WIDTH-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  clws_pkg::clws_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output clws_pkg::clws_out_t                 out_data
);
    import clws_pkg::*;

    // front to queue
    logic     q_push;
    logic     q_full;
    clws_op_t q_wdata;

    // queue to back
    logic     q_pop;
    logic     q_not_empty;
    clws_op_t q_rdata;

    // request decode, stalls only on a full queue
    clws_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // decouples the request side from a stalled result side
    clws_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    // strobe sequencer and result register
    clws_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// ===== hw/rtl/clws_checker.sv =====
// port-level checks for the character lcd write sequencer, bound to the top level
// depends on clws_pkg and char_lcd_write_sequencer_unit
module clws_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input clws_pkg::clws_out_t out_data
);
    import clws_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // enable only pulses inside a busy write
    a_e_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.e_pin |-> out_data.busy_res)
        else $error("enable high while idle");

    // a dropped request leaves the block busy
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rejected |-> out_data.busy_res)
        else $error("rejected while idle");

endmodule

bind char_lcd_write_sequencer_unit clws_checker u_clws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/sv/char_lcd_write_sequencer_unit_test.sv =====
// self-checking testbench for char_lcd_write_sequencer_unit: sends ticks and lcd write requests,
// predicts the bus levels of every result transaction and compares them in order
// depends on clws_pkg and the rtl of char_lcd_write_sequencer_unit
module char_lcd_write_sequencer_unit_test;

    import clws_pkg::*;

    localparam int COUNT_WIDTH     = 20;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_ROUNDS   = 3;
    localparam int ROUND_ITEMS     = 50;
    localparam int RESET_TICKS     = 242;

    // func codes the block ignores
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    localparam logic [CFG_WIDTH-1:0] TICKS_MAX = {CFG_WIDTH{1'b1}};

    // one entry of the clear or init sequence
    typedef struct packed {
        logic                     present;
        logic                     is_wait;
        logic [CFG_IDX_WIDTH-1:0] reg_idx;
        logic [7:0]               value;
    } lcd_seq_entry_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_addr  = '0;
    logic [CFG_WIDTH-1:0]     cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    clws_in_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    clws_out_t                out_data;

    // idling controls shared by the sender, the receiver and the tests
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    bit hold_results    = 1'b0;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // bus levels still owed by the block, oldest first
    clws_out_t pending_bus_levels[$];

    // predicted state of the sequencer
    logic [CFG_WIDTH-1:0]   timing_reg [NUM_REGS] = '{RST_SETUP, RST_PULSE, RST_HOLD,
                                                      RST_CLEAR_WAIT, RST_POWERUP,
                                                      RST_WAKE_FIRST, RST_WAKE_LATER};
    clws_phase_t            lcd_phase  = PH_IDLE;
    logic [COUNT_WIDTH-1:0] ticks_left = '0;
    logic [7:0]             bus_byte   = '0;
    logic                   bus_rs     = 1'b0;
    clws_seq_t              seq_kind   = SEQ_NONE;
    logic [STEP_WIDTH-1:0]  seq_step   = '0;

    char_lcd_write_sequencer_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // clear: write 0x01, wait, write 0x02, wait
    // init: power-up wait, three wake-up writes each followed by a wait, then four set-up writes
    function automatic lcd_seq_entry_t sequence_entry(input clws_seq_t kind,
                                                      input logic [STEP_WIDTH-1:0] step);
        lcd_seq_entry_t e;
        e = '0;
        if (kind == SEQ_CLEAR && step < 4'd4)
        begin
            e.present = 1'b1;
            e.is_wait = step[0];
            e.reg_idx = REG_CLEAR_WAIT;
            e.value   = (step == 4'd0) ? LCD_CLR_DISP : LCD_HOME;
        end
        else if (kind == SEQ_INIT && step < 4'd11)
        begin
            e.present = 1'b1;
            // even steps up to six are waits, everything else is a command write
            e.is_wait = !step[0] && step < 4'd7;
            case (step)
                4'd0:    e.reg_idx = REG_POWERUP;
                4'd2:    e.reg_idx = REG_WAKE_FIRST;
                default: e.reg_idx = REG_WAKE_LATER;
            endcase
            case (step)
                4'd7:    e.value = LCD_FUNC_SET;
                4'd8:    e.value = LCD_SHIFT;
                4'd9:    e.value = LCD_DISP_ON;
                4'd10:   e.value = LCD_ENTRY;
                default: e.value = LCD_WAKE;
            endcase
        end
        return e;
    endfunction

    function automatic void load_phase(input clws_phase_t ph,
                                       input logic [CFG_IDX_WIDTH-1:0] idx);
        lcd_phase  = ph;
        ticks_left = COUNT_WIDTH'(timing_reg[idx]);
    endfunction

    function automatic void begin_write(input logic [7:0] value, input logic rs);
        bus_byte = value;
        bus_rs   = rs;
        load_phase(PH_SETUP, REG_SETUP);
    endfunction

    // start the sequence entry at seq_step, or fall back to idle past the end
    function automatic void enter_sequence_step();
        lcd_seq_entry_t entry;
        entry = sequence_entry(seq_kind, seq_step);
        if (!entry.present)
        begin
            lcd_phase  = PH_IDLE;
            ticks_left = '0;
            seq_kind   = SEQ_NONE;
            seq_step   = '0;
        end
        else if (entry.is_wait)
            load_phase(PH_WAIT, entry.reg_idx);
        else
            begin_write(entry.value, 1'b0);
    endfunction

    // apply one request to the predicted state and return the bus levels it leaves
    function automatic clws_out_t predict_bus_levels(input clws_in_t req);
        clws_out_t levels;
        logic      dropped;
        dropped = 1'b0;
        case (req.func)
            FUNC_TICK:
            begin
                // a tick while idle does nothing
                if (lcd_phase != PH_IDLE)
                begin
                    if (ticks_left > COUNT_WIDTH'(1))
                        ticks_left = ticks_left - COUNT_WIDTH'(1);
                    else if (lcd_phase == PH_SETUP)
                        load_phase(PH_PULSE, REG_PULSE);
                    else if (lcd_phase == PH_PULSE)
                        load_phase(PH_HOLD, REG_HOLD);
                    else
                    begin
                        seq_step = seq_step + STEP_WIDTH'(1);
                        enter_sequence_step();
                    end
                end
            end
            FUNC_CMD, FUNC_CHAR, FUNC_CLEAR, FUNC_INIT:
            begin
                // a request while busy is dropped and is not a tick either
                if (lcd_phase != PH_IDLE)
                    dropped = 1'b1;
                else
                begin
                    seq_step = '0;
                    case (req.func)
                        FUNC_CMD:
                        begin
                            seq_kind = SEQ_NONE;
                            begin_write(req.byte_value, 1'b0);
                        end
                        FUNC_CHAR:
                        begin
                            seq_kind = SEQ_NONE;
                            begin_write(req.byte_value, 1'b1);
                        end
                        FUNC_CLEAR:
                        begin
                            seq_kind = SEQ_CLEAR;
                            enter_sequence_step();
                        end
                        default:
                        begin
                            // init pulls rs low right away, even during the power-up wait
                            seq_kind = SEQ_INIT;
                            bus_rs   = 1'b0;
                            enter_sequence_step();
                        end
                    endcase
                end
            end
            default: ;
        endcase
        levels.data_pins = bus_byte;
        levels.rs_pin    = bus_rs;
        levels.e_pin     = (lcd_phase == PH_PULSE);
        levels.busy_res  = (lcd_phase != PH_IDLE);
        levels.rejected  = dropped;
        return levels;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    // every result transaction is matched against the oldest prediction
    always @(posedge clk)
    begin
        clws_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bus_levels.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_bus_levels.pop_front();
                check_field("data_pins", want.data_pins, out_data.data_pins);
                check_field("rs_pin", 8'(want.rs_pin), 8'(out_data.rs_pin));
                check_field("e_pin", 8'(want.e_pin), 8'(out_data.e_pin));
                check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
                check_field("rejected", 8'(want.rejected), 8'(out_data.rejected));
            end
        end
    end

    // ends a hung run: cycles in which neither channel moves a transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, long ready stretches, and one long hold-off on request
    initial
    begin
        int span;
        forever
        begin
            if (hold_results)
            begin
                out_ready    <= 1'b0;
                span         = HOLD_OFF_CYCLES;
                hold_results = 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                span      = $urandom_range(1, 9);
            end
            else
            begin
                out_ready <= 1'b1;
                span      = $urandom_range(1, 20);
            end
            repeat (span) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one request; valid stays high afterwards so back-to-back transactions need no gap
    task automatic send_request(input logic [2:0] func, input logic [7:0] value);
        clws_in_t req;
        req.func       = func;
        req.byte_value = value;
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_bus_levels.push_back(predict_bus_levels(req));
    endtask

    task automatic tick_until_idle();
        while (lcd_phase != PH_IDLE)
            send_request(FUNC_TICK, 8'($urandom_range(0, 255)));
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_bus_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_WIDTH-1:0] idx,
                                  input logic [CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        // a zero count behaves as one
        timing_reg[idx] = (value == '0) ? CFG_WIDTH'(1) : value;
    endtask

    // rewrite all timing registers once the pipeline is empty
    task automatic program_timing(input logic [CFG_WIDTH-1:0] setup,
                                  input logic [CFG_WIDTH-1:0] pulse,
                                  input logic [CFG_WIDTH-1:0] hold,
                                  input logic [CFG_WIDTH-1:0] clear_wait,
                                  input logic [CFG_WIDTH-1:0] powerup,
                                  input logic [CFG_WIDTH-1:0] wake_first,
                                  input logic [CFG_WIDTH-1:0] wake_later);
        wait_for_results();
        write_register(REG_SETUP, setup);
        write_register(REG_PULSE, pulse);
        write_register(REG_HOLD, hold);
        write_register(REG_CLEAR_WAIT, clear_wait);
        write_register(REG_POWERUP, powerup);
        write_register(REG_WAKE_FIRST, wake_first);
        write_register(REG_WAKE_LATER, wake_later);
        cfg_we <= 1'b0;
    endtask

    // short counts keep sequences finishing within a few dozen ticks; zero shows up often
    function automatic logic [CFG_WIDTH-1:0] random_count();
        if ($urandom_range(0, 7) == 0)
            return CFG_WIDTH'($urandom_range(5, 24));
        return CFG_WIDTH'($urandom_range(0, 4));
    endfunction

    // mostly well-formed traffic: start a request when idle, tick it through,
    // with some dropped requests and ignored codes mixed in
    task automatic random_traffic(input int count);
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (lcd_phase == PH_IDLE ? pick < 70 : (pick >= 85 && pick < 95))
                send_request(3'($urandom_range(FUNC_CMD, FUNC_INIT)),
                             8'($urandom_range(0, 255)));
            else if (lcd_phase == PH_IDLE ? pick < 90 : pick < 85)
                send_request(FUNC_TICK, 8'($urandom_range(0, 255)));
            else
                send_request(3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)),
                             8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset timing: a command write ticked past the end of its setup into the pulse,
    // with drops while it runs; the pulse is left running for the next test
    task automatic test_reset_timing();
        send_request(FUNC_CMD, 8'hA5);
        send_request(FUNC_CHAR, 8'h5A);
        send_request(FUNC_INIT, 8'h00);
        repeat (RESET_TICKS) send_request(FUNC_TICK, 8'($urandom_range(0, 255)));
        send_request(FUNC_CLEAR, 8'hFF);
        send_request(FUNC_UNUSED_LO, 8'h00);
    endtask

    // shortest counts, a zero count, every request kind and the ignored codes;
    // the pulse still running from reset keeps its count, the hold after it is short
    task automatic test_extreme_timing();
        program_timing('0, CFG_WIDTH'(1), CFG_WIDTH'(1), '0, CFG_WIDTH'(1), CFG_WIDTH'(1),
                       CFG_WIDTH'(2));
        send_request(FUNC_CMD, 8'h00);
        send_request(FUNC_CHAR, 8'hFF);
        tick_until_idle();
        // tick with nothing in progress
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_CHAR, 8'hFF);
        send_request(FUNC_UNUSED_HI, 8'hFF);
        tick_until_idle();
        send_request(FUNC_UNUSED_HI, 8'h00);
        send_request(FUNC_CLEAR, 8'h00);
        send_request(FUNC_CMD, 8'h3C);
        tick_until_idle();
        send_request(FUNC_INIT, 8'hFF);
        send_request(FUNC_TICK, 8'hFF);
        send_request(FUNC_TICK, 8'h00);
    endtask

    // counts rewritten while init is still running apply from the next phase load
    task automatic test_register_write_midway();
        program_timing(CFG_WIDTH'(2), CFG_WIDTH'(3), CFG_WIDTH'(2), CFG_WIDTH'(4),
                       CFG_WIDTH'(3), CFG_WIDTH'(5), CFG_WIDTH'(1));
        repeat (4) send_request(FUNC_TICK, 8'($urandom_range(0, 255)));
        program_timing(CFG_WIDTH'(1), CFG_WIDTH'(2), CFG_WIDTH'(3), CFG_WIDTH'(1),
                       CFG_WIDTH'(2), CFG_WIDTH'(1), CFG_WIDTH'(4));
        tick_until_idle();
    endtask

    // results held off for a long stretch while requests keep coming: input must stall
    task automatic test_input_backpressure();
        sender_gaps  = 1'b0;
        hold_results = 1'b1;
        random_traffic(60);
        sender_gaps = 1'b1;
    endtask

    // random timing per round; the last round runs without idling on either side
    task automatic test_random_traffic();
        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            if (r == RANDOM_ROUNDS - 1)
            begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            program_timing(random_count(), random_count(), random_count(), random_count(),
                           random_count(), random_count(), random_count());
            random_traffic(ROUND_ITEMS);
        end
    endtask

    // largest counts: only the countdown of the first phase is walked, the block stays busy
    task automatic test_maximum_counts();
        tick_until_idle();
        program_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX,
                       TICKS_MAX);
        send_request(FUNC_CMD, 8'h5A);
        repeat (20) send_request(FUNC_TICK, 8'($urandom_range(0, 255)));
        send_request(FUNC_CLEAR, 8'h81);
        send_request(FUNC_CHAR, 8'h7E);
        repeat (5) send_request(FUNC_TICK, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_timing();
        test_extreme_timing();
        test_register_write_midway();
        test_input_backpressure();
        test_random_traffic();
        test_maximum_counts();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
